FILE: rtl/uffk_pkg.sv
// Shared types and constants for the uniform-field flight kinematics block.
// Depends on nothing; imported by uniform_field_flight_kinematics.
package uffk_pkg;

  // Default fraction width of all fixed-point values.
  localparam int FRAC_BITS_DEF = 16;

  // Widths of the square-root stages, of the divisor and of the flight time.
  localparam int ROOT_W = 64;
  localparam int RAD_W  = 128;
  localparam int DEN_W  = 64;
  localparam int TIME_W = 48;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NEG_ENERGY = 2'd1,
    ST_BAD_TIME   = 2'd2,
    ST_SATURATED  = 2'd3
  } status_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_FIELD  = 1'b0,
    REG_LENGTH = 1'b1
  } cfg_idx_t;

  // Per-item data that rides along the front half of the pipeline.
  typedef struct packed {
    logic               zero_force;
    logic               fneg;
    logic               neg_energy;
    logic signed [31:0] p0;
    logic [61:0]        ml;
    logic [62:0]        fmag;
  } side_t;

  // Per-item data that rides along the divider.
  typedef struct packed {
    side_t              side;
    logic signed [64:0] p1;
    logic               neg_time;
  } post_t;

endpackage

FILE: rtl/uniform_field_flight_kinematics.sv
// Top level of the uniform-field flight kinematics block: multipliers,
// a 64-stage square-root pipeline and a one-bit-per-stage divider.
// Depends on uffk_pkg.
//
//   channel   direction  handshake            word
//   command   in         start && !busy       particle_mass, particle_charge, entry_momentum
//   result    out        done (one cycle)     exit_momentum, flight_time, status
//   config    in         cfg_we               cfg_index, cfg_wdata
//
// One word enters per cycle; busy is never raised. Each word passes
// through four multiply and add stages, 64 square-root stages, two operand
// stages, one divider stage per quotient bit and one output stage.
// Reset clears the valid bits and loads the register reset values.
// The receiver cannot stall, so no word is ever held back.
module uniform_field_flight_kinematics
  import uffk_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [30:0]        particle_mass,
  input  logic signed [31:0] particle_charge,
  input  logic signed [31:0] entry_momentum,
  output logic               done,
  output logic signed [31:0] exit_momentum,
  output logic [47:0]        flight_time,
  output logic [1:0]         status,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int QW = 64 + 2 * FRAC_BITS;

  // Configuration registers.
  logic signed [31:0] field_strength;
  logic [30:0]        region_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_strength <= '0;
      region_length  <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_FIELD:  field_strength <= cfg_wdata;
        REG_LENGTH: region_length  <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: three narrow products and the force sign.
  logic [31:0] e_mag, q_mag, p_mag;
  logic [63:0] fmag_full;
  assign e_mag = field_strength[31] ? (~field_strength + 32'd1) : field_strength;
  assign q_mag = particle_charge[31] ? (~particle_charge + 32'd1) : particle_charge;
  assign p_mag = entry_momentum[31] ? (~entry_momentum + 32'd1) : entry_momentum;
  assign fmag_full = e_mag * q_mag;

  logic        v1;
  side_t       s1_side;
  logic [63:0] s1_psq;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start;
  end

  always_ff @(posedge clk) begin
    s1_side.zero_force <= (field_strength == 32'sd0) || (particle_charge == 32'sd0);
    s1_side.fneg       <= field_strength[31] ^ particle_charge[31];
    s1_side.neg_energy <= 1'b0;
    s1_side.p0         <= entry_momentum;
    s1_side.ml         <= particle_mass * region_length;
    s1_side.fmag       <= fmag_full[62:0];
    s1_psq             <= p_mag * p_mag;
  end

  // Stage 2: partial products of mass-length times force.
  logic        v2;
  side_t       s2_side;
  logic [63:0] s2_psq;
  logic [63:0] pp_ll;
  logic [62:0] pp_lh;
  logic [61:0] pp_hl;
  logic [60:0] pp_hh;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  always_ff @(posedge clk) begin
    s2_side <= s1_side;
    s2_psq  <= s1_psq;
    pp_ll   <= s1_side.ml[31:0] * s1_side.fmag[31:0];
    pp_lh   <= s1_side.ml[31:0] * s1_side.fmag[62:32];
    pp_hl   <= s1_side.ml[61:32] * s1_side.fmag[31:0];
    pp_hh   <= s1_side.ml[61:32] * s1_side.fmag[62:32];
  end

  // Stage 3: work term 2*m*len*f and the scaled momentum square.
  logic               v3;
  side_t              s3_side;
  logic [RAD_W-1:0]   s3_work, s3_base, work_sum;
  assign work_sum = ({67'd0, pp_hh} << 64) + ({65'd0, pp_lh} << 32)
                  + ({66'd0, pp_hl} << 32) + {64'd0, pp_ll};

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  always_ff @(posedge clk) begin
    s3_side <= s2_side;
    s3_work <= work_sum << 1;
    s3_base <= {64'd0, s2_psq} << (2 * FRAC_BITS);
  end

  // Stage 4: energy sum, negative-energy check and radicand.
  logic [RAD_W-1:0] energy;
  side_t            sq_side_in;
  assign energy = s3_side.fneg ? (s3_base - s3_work) : (s3_base + s3_work);

  always_comb begin
    sq_side_in            = s3_side;
    sq_side_in.neg_energy = s3_side.fneg && (s3_work > s3_base);
  end

  logic             sq_v    [0:ROOT_W];
  logic [RAD_W-1:0] sq_x    [0:ROOT_W];
  logic [ROOT_W-1:0] sq_r   [0:ROOT_W];
  side_t            sq_side [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else     sq_v[0] <= v3;
  end

  always_ff @(posedge clk) begin
    sq_side[0] <= sq_side_in;
    sq_x[0]    <= energy >> (2 * FRAC_BITS);
    sq_r[0]    <= '0;
  end

  // Square root, one result bit per stage from the top bit down. The residual
  // holds radicand minus root squared.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    localparam int I = ROOT_W - 1 - k;
    logic [RAD_W+1:0] trial;
    logic             fits;
    assign trial = ({{(RAD_W + 2 - ROOT_W){1'b0}}, sq_r[k]} << (I + 1))
                 + ({{(RAD_W + 1){1'b0}}, 1'b1} << (2 * I));
    assign fits  = {2'b00, sq_x[k]} >= trial;

    always_ff @(posedge clk) begin
      if (rst) sq_v[k+1] <= 1'b0;
      else     sq_v[k+1] <= sq_v[k];
    end

    always_ff @(posedge clk) begin
      sq_side[k+1] <= sq_side[k];
      sq_x[k+1]    <= fits ? (sq_x[k] - trial[RAD_W-1:0]) : sq_x[k];
      sq_r[k+1]    <= fits ? (sq_r[k] | (ROOT_W'(1) << I)) : sq_r[k];
    end
  end

  // Operand stage A: signed exit momentum and momentum change.
  logic               pa_v;
  side_t              pa_side;
  logic signed [64:0] pa_p1, p1_comb;
  logic signed [65:0] pa_d;
  assign p1_comb = sq_side[ROOT_W].fneg ? -$signed({1'b0, sq_r[ROOT_W]})
                                        : $signed({1'b0, sq_r[ROOT_W]});

  always_ff @(posedge clk) begin
    if (rst) pa_v <= 1'b0;
    else     pa_v <= sq_v[ROOT_W];
  end

  always_ff @(posedge clk) begin
    pa_side <= sq_side[ROOT_W];
    pa_p1   <= p1_comb;
    pa_d    <= {p1_comb[64], p1_comb} - {{34{sq_side[ROOT_W].p0[31]}}, sq_side[ROOT_W].p0};
  end

  // Operand stage B: time sign check and divider operands. A drift item
  // divides mass-length by momentum; a field item divides the scaled
  // momentum change by the force.
  logic [65:0]      d_mag;
  logic [QW-1:0]    num_comb;
  logic [DEN_W-1:0] den_comb;
  assign d_mag = pa_d[65] ? (~pa_d + 66'd1) : pa_d;

  always_comb begin
    if (pa_side.zero_force) begin
      num_comb = {{(QW - 62){1'b0}}, pa_side.ml};
      den_comb = (pa_side.p0 > 32'sd0) ? {32'd0, pa_side.p0} : DEN_W'(1);
    end else begin
      num_comb = {{(QW - 64){1'b0}}, d_mag[63:0]} << (2 * FRAC_BITS);
      den_comb = {1'b0, pa_side.fmag};
    end
  end

  logic             dv_v   [0:QW];
  logic [DEN_W-1:0] dv_rem [0:QW];
  logic [QW-1:0]    dv_nq  [0:QW];
  logic [DEN_W-1:0] dv_den [0:QW];
  post_t            dv_post[0:QW];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else     dv_v[0] <= pa_v;
  end

  always_ff @(posedge clk) begin
    dv_post[0].side     <= pa_side;
    dv_post[0].p1       <= pa_p1;
    dv_post[0].neg_time <= (pa_d != 66'sd0) && (pa_d[65] != pa_side.fneg);
    dv_rem[0]           <= '0;
    dv_nq[0]            <= num_comb;
    dv_den[0]           <= den_comb;
  end

  // Restoring division, one quotient bit per stage. The numerator shifts out
  // of the top of dv_nq while quotient bits shift in at the bottom.
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [DEN_W:0] trial;
    logic           ge;
    logic [DEN_W:0] diff;
    assign trial = {dv_rem[j], dv_nq[j][QW-1]};
    assign ge    = trial >= {1'b0, dv_den[j]};
    assign diff  = trial - {1'b0, dv_den[j]};

    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else     dv_v[j+1] <= dv_v[j];
    end

    always_ff @(posedge clk) begin
      dv_post[j+1] <= dv_post[j];
      dv_den[j+1]  <= dv_den[j];
      dv_rem[j+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      dv_nq[j+1]   <= {dv_nq[j][QW-2:0], ge};
    end
  end

  // Output stage: special cases, saturation and status.
  post_t              fin;
  logic [QW-1:0]      quo;
  logic               quo_big;
  logic signed [31:0] p_out;
  logic [47:0]        t_out;
  status_t            st_out;
  assign fin     = dv_post[QW];
  assign quo     = dv_nq[QW];
  assign quo_big = |quo[QW-1:TIME_W];

  always_comb begin
    p_out  = fin.side.p0;
    t_out  = '0;
    st_out = ST_OK;
    if (fin.side.zero_force) begin
      if (fin.side.p0 == 32'sd0) begin
        st_out = ST_BAD_TIME;
      end else if (fin.side.p0 < 32'sd0) begin
        st_out = (fin.side.ml != 62'd0) ? ST_BAD_TIME : ST_OK;
      end else if (quo_big) begin
        t_out  = '1;
        st_out = ST_SATURATED;
      end else begin
        t_out = quo[TIME_W-1:0];
      end
    end else if (fin.side.neg_energy) begin
      p_out  = '0;
      st_out = ST_NEG_ENERGY;
    end else begin
      if (fin.neg_time) begin
        st_out = ST_BAD_TIME;
      end else if (quo_big) begin
        t_out  = '1;
        st_out = ST_SATURATED;
      end else begin
        t_out = quo[TIME_W-1:0];
      end
      if (fin.p1 > 65'sd2147483647) begin
        p_out = 32'sh7FFFFFFF;
        if (st_out == ST_OK) st_out = ST_SATURATED;
      end else if (fin.p1 < -65'sd2147483648) begin
        p_out = 32'sh80000000;
        if (st_out == ST_OK) st_out = ST_SATURATED;
      end else begin
        p_out = fin.p1[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv_v[QW];
  end

  always_ff @(posedge clk) begin
    exit_momentum <= p_out;
    flight_time   <= t_out;
    status        <= st_out;
  end

endmodule
